FILE: sv/bis_pkg.sv
// Package with the constants, types and codes shared by the bilinear image scaler.
`timescale 1ns / 1ps

package bis_pkg;

   localparam int MAX_SRC_WIDTH  = 512;
   localparam int MAX_SRC_HEIGHT = 512;
   localparam int FRAC_BITS      = 16;

   localparam int COL_BITS   = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_SRC_HEIGHT);
   localparam int ADDR_BITS  = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
   localparam int DEPTH      = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int SW_BITS    = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SH_BITS    = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int SIZE_BITS  = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
   localparam int STEP_BITS  = SIZE_BITS + FRAC_BITS;
   localparam int VIEW_BITS  = 10;
   localparam int COORD_BITS = 13;
   localparam int POS_BITS   = COORD_BITS + STEP_BITS;
   localparam int IP_BITS    = POS_BITS - FRAC_BITS;
   localparam int WX_BITS    = FRAC_BITS + 1;
   localparam int W_BITS     = 2 * FRAC_BITS + 1;
   localparam int ACC_BITS   = W_BITS + 8 + 2;
   localparam int CSR_BITS   = 13;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH   = 3'd0,
      REG_SRC_HEIGHT  = 3'd1,
      REG_VIEW_X      = 3'd2,
      REG_VIEW_Y      = 3'd3,
      REG_VIEW_WIDTH  = 3'd4,
      REG_VIEW_HEIGHT = 3'd5,
      REG_DST_WIDTH   = 3'd6,
      REG_DST_HEIGHT  = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POS,
      ST_WGT,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_ACC_DONE
   } state_type;

   typedef struct packed {
      logic       take;
      logic       capture;
      logic       pos_en;
      logic       wgt_en;
      logic       rd_en;
      logic [1:0] rd_idx;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic req_hit;
      logic div_busy;
      logic out_free;
      logic acc_busy;
   } status_type;

endpackage

FILE: sv/bis_ram.sv
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module bis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/bis_divider.sv
// Restoring divider that computes one quotient bit per cycle.
`timescale 1ns / 1ps

module bis_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [bis_pkg::STEP_BITS-1:0]     dividend,
   input  logic [bis_pkg::VIEW_BITS-1:0]     divisor,
   output logic                              busy,
   output logic [bis_pkg::STEP_BITS-1:0]     quotient
);

   localparam int NB = bis_pkg::STEP_BITS;
   localparam int VB = bis_pkg::VIEW_BITS;
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0] num_ff, num_in;
   logic [VB-1:0] rem_ff, rem_in;
   logic [VB-1:0] den_ff, den_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [VB:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[NB-1]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = (divisor == '0) ? VB'(1) : divisor;
         cnt_in  = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = VB'(trial - {1'b0, den_ff});
            num_in = {num_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = trial[VB-1:0];
            num_in = {num_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

FILE: sv/bis_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module bis_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bis_pkg::status_type    status,
   output bis_pkg::cmd_type       cmd
);

   bis_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         bis_pkg::ST_IDLE: begin
            req_stall = status.div_busy;
            if (req_valid && !status.div_busy) begin
               cmd.take = 1'b1;
               if (status.req_hit) begin
                  cmd.capture = 1'b1;
                  state_in    = bis_pkg::ST_POS;
               end
            end
         end
         bis_pkg::ST_POS: begin
            cmd.pos_en = 1'b1;
            state_in   = bis_pkg::ST_WGT;
         end
         bis_pkg::ST_WGT: begin
            cmd.wgt_en = 1'b1;
            state_in   = bis_pkg::ST_RD0;
         end
         bis_pkg::ST_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = 2'd0;
            state_in   = bis_pkg::ST_RD1;
         end
         bis_pkg::ST_RD1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = 2'd1;
            state_in   = bis_pkg::ST_RD2;
         end
         bis_pkg::ST_RD2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = 2'd2;
            state_in   = bis_pkg::ST_RD3;
         end
         bis_pkg::ST_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = 2'd3;
            state_in   = bis_pkg::ST_ACC_DONE;
         end
         bis_pkg::ST_ACC_DONE: begin
            if (!status.acc_busy && status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bis_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/bis_datapath.sv
// Datapath with registers, step dividers, frame store, blend and result register.
`timescale 1ns / 1ps

module bis_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bis_pkg::cmd_type       cmd,
   output bis_pkg::status_type    status,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [12:0]            csr_data,
   input  logic                   req_func,
   input  logic [8:0]             req_src_col,
   input  logic [8:0]             req_src_row,
   input  logic [7:0]             req_in_red,
   input  logic [7:0]             req_in_green,
   input  logic [7:0]             req_in_blue,
   input  logic [7:0]             req_in_alpha,
   input  logic [11:0]            req_dst_col,
   input  logic [11:0]            req_dst_row,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_red,
   output logic [7:0]             rsp_out_green,
   output logic [7:0]             rsp_out_blue,
   output logic [7:0]             rsp_out_alpha,
   output logic [11:0]            rsp_out_col,
   output logic [11:0]            rsp_out_row
);

   localparam int FB  = bis_pkg::FRAC_BITS;
   localparam int SZ  = bis_pkg::SIZE_BITS;
   localparam int ST  = bis_pkg::STEP_BITS;
   localparam int CO  = bis_pkg::COORD_BITS;
   localparam int PB  = bis_pkg::POS_BITS;
   localparam int IPB = bis_pkg::IP_BITS;
   localparam int WXB = bis_pkg::WX_BITS;
   localparam int WB  = bis_pkg::W_BITS;
   localparam int AB  = bis_pkg::ACC_BITS;
   localparam int CB  = bis_pkg::COL_BITS;
   localparam int RB  = bis_pkg::ROW_BITS;
   localparam int AW  = bis_pkg::ADDR_BITS;

   logic [9:0]  src_width_ff, src_height_ff, view_width_ff, view_height_ff;
   logic [8:0]  view_x_ff, view_y_ff;
   logic [12:0] dst_width_ff, dst_height_ff;
   logic        div_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= 10'd512;
         src_height_ff  <= 10'd512;
         view_x_ff      <= '0;
         view_y_ff      <= '0;
         view_width_ff  <= 10'd512;
         view_height_ff <= 10'd512;
         dst_width_ff   <= 13'd512;
         dst_height_ff  <= 13'd512;
         div_start_ff   <= 1'b1;
      end else begin
         div_start_ff <= csr_valid;
         if (csr_valid) begin
            unique case (bis_pkg::reg_index_type'(csr_index))
               bis_pkg::REG_SRC_WIDTH:   src_width_ff   <= csr_data[9:0];
               bis_pkg::REG_SRC_HEIGHT:  src_height_ff  <= csr_data[9:0];
               bis_pkg::REG_VIEW_X:      view_x_ff      <= csr_data[8:0];
               bis_pkg::REG_VIEW_Y:      view_y_ff      <= csr_data[8:0];
               bis_pkg::REG_VIEW_WIDTH:  view_width_ff  <= csr_data[9:0];
               bis_pkg::REG_VIEW_HEIGHT: view_height_ff <= csr_data[9:0];
               bis_pkg::REG_DST_WIDTH:   dst_width_ff   <= csr_data;
               bis_pkg::REG_DST_HEIGHT:  dst_height_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   logic [SZ-1:0] sw_eff, sh_eff;

   always_comb begin
      if (src_width_ff == '0) begin
         sw_eff = SZ'(1);
      end else if (32'(src_width_ff) > bis_pkg::MAX_SRC_WIDTH) begin
         sw_eff = SZ'(bis_pkg::MAX_SRC_WIDTH);
      end else begin
         sw_eff = SZ'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         sh_eff = SZ'(1);
      end else if (32'(src_height_ff) > bis_pkg::MAX_SRC_HEIGHT) begin
         sh_eff = SZ'(bis_pkg::MAX_SRC_HEIGHT);
      end else begin
         sh_eff = SZ'(src_height_ff);
      end
   end

   logic [ST-1:0] step_x, step_y;
   logic          busy_x, busy_y;

   bis_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (ST'(sw_eff) << FB),
      .divisor  (view_width_ff),
      .busy     (busy_x),
      .quotient (step_x)
   );

   bis_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (ST'(sh_eff) << FB),
      .divisor  (view_height_ff),
      .busy     (busy_y),
      .quotient (step_y)
   );

   logic [CO-1:0] coord_x_ff, coord_y_ff;
   logic [11:0]   col_ff, row_ff;
   logic [PB-1:0] pos_x_ff, pos_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         coord_x_ff <= CO'(req_dst_col) + CO'(view_x_ff);
         coord_y_ff <= CO'(req_dst_row) + CO'(view_y_ff);
         col_ff     <= req_dst_col;
         row_ff     <= req_dst_row;
      end
      if (cmd.pos_en) begin
         pos_x_ff <= PB'(coord_x_ff) * PB'(step_x);
         pos_y_ff <= PB'(coord_y_ff) * PB'(step_y);
      end
   end

   logic [IPB-1:0] ipx, ipy, lastx, lasty;
   logic [IPB-1:0] x0, x1, y0, y1;
   logic [WXB-1:0] wx0, wx1, wy0, wy1;

   always_comb begin
      ipx   = pos_x_ff[PB-1:FB];
      ipy   = pos_y_ff[PB-1:FB];
      lastx = IPB'(sw_eff) - IPB'(1);
      lasty = IPB'(sh_eff) - IPB'(1);
      x0    = (ipx > lastx) ? lastx : ipx;
      y0    = (ipy > lasty) ? lasty : ipy;
      x1    = ((ipx + IPB'(1)) > lastx) ? lastx : ipx + IPB'(1);
      y1    = ((ipy + IPB'(1)) > lasty) ? lasty : ipy + IPB'(1);
      wx1   = WXB'(pos_x_ff[FB-1:0]);
      wy1   = WXB'(pos_y_ff[FB-1:0]);
      wx0   = (WXB'(1) << FB) - wx1;
      wy0   = (WXB'(1) << FB) - wy1;
   end

   logic [CB-1:0] x0_ff, x1_ff;
   logic [RB-1:0] y0_ff, y1_ff;
   logic [WB-1:0] w_ff [4];

   always_ff @(posedge clock) begin
      if (cmd.wgt_en) begin
         x0_ff   <= x0[CB-1:0];
         x1_ff   <= x1[CB-1:0];
         y0_ff   <= y0[RB-1:0];
         y1_ff   <= y1[RB-1:0];
         w_ff[0] <= WB'(wx0 * wy0);
         w_ff[1] <= WB'(wx1 * wy0);
         w_ff[2] <= WB'(wx0 * wy1);
         w_ff[3] <= WB'(wx1 * wy1);
      end
   end

   logic          store_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_rdata;
   logic [CB-1:0] rd_col;
   logic [RB-1:0] rd_row;

   assign store_we = cmd.take && !req_func
                  && (32'(req_src_col) < bis_pkg::MAX_SRC_WIDTH)
                  && (32'(req_src_row) < bis_pkg::MAX_SRC_HEIGHT);

   always_comb begin
      rd_col = cmd.rd_idx[0] ? x1_ff : x0_ff;
      rd_row = cmd.rd_idx[1] ? y1_ff : y0_ff;
      if (cmd.rd_en) begin
         ram_addr = AW'(rd_row) * AW'(bis_pkg::MAX_SRC_WIDTH) + AW'(rd_col);
      end else begin
         ram_addr = AW'(req_src_row) * AW'(bis_pkg::MAX_SRC_WIDTH) + AW'(req_src_col);
      end
   end

   bis_ram #(
      .WIDTH (32),
      .DEPTH (bis_pkg::DEPTH)
   ) u_frame_store (
      .clock (clock),
      .we    (store_we),
      .addr  (ram_addr),
      .wdata ({req_in_alpha, req_in_blue, req_in_green, req_in_red}),
      .rdata (ram_rdata)
   );

   logic          acc_vld_ff;
   logic [1:0]    acc_idx_ff;
   logic [AB-1:0] acc_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= 1'b0;
      end else begin
         acc_vld_ff <= cmd.rd_en;
      end
      acc_idx_ff <= cmd.rd_idx;
      for (int c = 0; c < 4; c++) begin
         if (cmd.wgt_en) begin
            acc_ff[c] <= '0;
         end else if (acc_vld_ff) begin
            acc_ff[c] <= acc_ff[c]
                       + AB'(ram_rdata[8*c +: 8]) * AB'(w_ff[acc_idx_ff]);
         end
      end
   end

   logic       rsp_valid_ff;
   logic [7:0] chan_ff [4];
   logic [11:0] out_col_ff, out_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         for (int c = 0; c < 4; c++) begin
            chan_ff[c] <= (acc_ff[c][AB-1:2*FB] > (AB-2*FB)'(255)) ? 8'd255
                        : acc_ff[c][2*FB +: 8];
         end
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
      end
   end

   assign status.req_hit  = req_func && (13'(req_dst_col) < dst_width_ff)
                                     && (13'(req_dst_row) < dst_height_ff);
   assign status.div_busy = div_start_ff || busy_x || busy_y;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.acc_busy = acc_vld_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = chan_ff[0];
   assign rsp_out_green = chan_ff[1];
   assign rsp_out_blue  = chan_ff[2];
   assign rsp_out_alpha = chan_ff[3];
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_row   = out_row_ff;

endmodule

FILE: sv/bilinear_image_scaler.sv
// Top level of the bilinear RGBA image scaler.
//
// The req channel carries two kinds of beats. A store beat (req_func low)
// writes one RGBA pixel into the frame store and gives no result. A request
// beat (req_func high) names a destination pixel; the block blends the four
// surrounding source pixels and returns one rsp beat with the channels and
// the destination coordinates, or nothing if the pixel lies outside the
// destination size. Store beats and dropped requests are taken in idle.
// A request goes from its beat to the result register through position
// and weight math, then four reads of the single-port frame store, one
// pixel per cycle, and the last accumulate. A new beat can be taken once
// the result is loaded, while that result waits, unless the dividers run.
// The csr channel is always ready; each write restarts the two step
// dividers, which hold req_stall high while they run. Reset clears the
// registers to their defaults and runs the dividers the same way; the
// frame store is not cleared. A stalled rsp beat holds, and the block
// finishes at most one more request behind it before it stalls req.
`timescale 1ns / 1ps

module bilinear_image_scaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [8:0]  req_src_col,
   input  logic [8:0]  req_src_row,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic [7:0]  req_in_alpha,
   input  logic [11:0] req_dst_col,
   input  logic [11:0] req_dst_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   output logic [11:0] rsp_out_col,
   output logic [11:0] rsp_out_row
);

   bis_pkg::cmd_type    cmd;
   bis_pkg::status_type status;

   assign csr_ready = 1'b1;

   bis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bis_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_func      (req_func),
      .req_src_col   (req_src_col),
      .req_src_row   (req_src_row),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .req_in_alpha  (req_in_alpha),
      .req_dst_col   (req_dst_col),
      .req_dst_row   (req_dst_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row)
   );

endmodule

FILE: sv/bis_checker.sv
// Port-level checker for the bilinear image scaler and its bind statement.
`timescale 1ns / 1ps

module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_out_col
);

   a_stall_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("req not stalled while steps are computed after reset");

   a_stall_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("req not stalled after a register write");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without the block being busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_col))
      else $error("stalled rsp beat changed");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
   .clock       (clock),
   .reset       (reset),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_col (rsp_out_col)
);

FILE: tb/testbench.sv
// Self-checking testbench for the bilinear image scaler, with its own pixel predictor.
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      bit        func;
      bit [8:0]  scol;
      bit [8:0]  srow;
      bit [7:0]  red;
      bit [7:0]  green;
      bit [7:0]  blue;
      bit [7:0]  alpha;
      bit [11:0] dcol;
      bit [11:0] drow;
   } pixel_beat_type;

   typedef struct {
      bit [7:0]  red;
      bit [7:0]  green;
      bit [7:0]  blue;
      bit [7:0]  alpha;
      bit [11:0] col;
      bit [11:0] row;
   } pixel_res_type;

   typedef struct {
      pixel_beat_type beat;
      bit             typed;
      pixel_res_type  want;
   } table_row_type;

   localparam int WATCH_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 12;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [12:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [8:0]  req_src_col;
   logic [8:0]  req_src_row;
   logic [7:0]  req_in_red;
   logic [7:0]  req_in_green;
   logic [7:0]  req_in_blue;
   logic [7:0]  req_in_alpha;
   logic [11:0] req_dst_col;
   logic [11:0] req_dst_row;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic [7:0]  rsp_out_alpha;
   logic [11:0] rsp_out_col;
   logic [11:0] rsp_out_row;

   bilinear_image_scaler u_top (.*);

   bit [31:0]     pixel_mem [0:bis_pkg::DEPTH-1];
   bit            pixel_set [0:bis_pkg::DEPTH-1];
   bit [12:0]     cfg [0:7];
   pixel_res_type pending_pixels[$];
   table_row_type directed[$];
   int            errors;
   int            watch_count;
   int            holds_asked;
   int            holds_done;
   int            hold_left;
   int            burst_left;
   bit            quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned eff_size(input bit [12:0] v, input int max);
      if (v == 0) return 1;
      return (v > max) ? longint'(max) : longint'(v);
   endfunction

   function automatic longint unsigned axis_step(input int src_reg, input int view_reg,
                                                 input int max);
      return (eff_size(cfg[src_reg], max) << bis_pkg::FRAC_BITS)
             / eff_size(cfg[view_reg], 1 << 13);
   endfunction

   function automatic void locate(input longint unsigned coord, input longint unsigned step,
                                  input longint unsigned size, output int i0, output int i1,
                                  output longint unsigned frac);
      longint unsigned pos, ip;
      pos  = coord * step;
      ip   = pos >> bis_pkg::FRAC_BITS;
      frac = pos & ((64'd1 << bis_pkg::FRAC_BITS) - 1);
      i0   = int'((ip > size - 1) ? size - 1 : ip);
      i1   = int'((ip + 1 > size - 1) ? size - 1 : ip + 1);
   endfunction

   function automatic bit in_dest(input pixel_beat_type b);
      return b.dcol < cfg[bis_pkg::REG_DST_WIDTH] && b.drow < cfg[bis_pkg::REG_DST_HEIGHT];
   endfunction

   function automatic void neighbours(input pixel_beat_type b, output int addr [4],
                                      output longint unsigned fx, output longint unsigned fy);
      int x0, x1, y0, y1;
      locate(longint'(b.dcol) + cfg[bis_pkg::REG_VIEW_X],
             axis_step(bis_pkg::REG_SRC_WIDTH, bis_pkg::REG_VIEW_WIDTH,
                       bis_pkg::MAX_SRC_WIDTH),
             eff_size(cfg[bis_pkg::REG_SRC_WIDTH], bis_pkg::MAX_SRC_WIDTH), x0, x1, fx);
      locate(longint'(b.drow) + cfg[bis_pkg::REG_VIEW_Y],
             axis_step(bis_pkg::REG_SRC_HEIGHT, bis_pkg::REG_VIEW_HEIGHT,
                       bis_pkg::MAX_SRC_HEIGHT),
             eff_size(cfg[bis_pkg::REG_SRC_HEIGHT], bis_pkg::MAX_SRC_HEIGHT), y0, y1, fy);
      addr[0] = y0 * bis_pkg::MAX_SRC_WIDTH + x0;
      addr[1] = y0 * bis_pkg::MAX_SRC_WIDTH + x1;
      addr[2] = y1 * bis_pkg::MAX_SRC_WIDTH + x0;
      addr[3] = y1 * bis_pkg::MAX_SRC_WIDTH + x1;
   endfunction

   function automatic pixel_res_type blend_pixel(input pixel_beat_type b);
      int addr [4];
      longint unsigned fx, fy, acc;
      longint unsigned w [4];
      longint unsigned one;
      bit [7:0] chan [4];
      pixel_res_type r;
      one = 64'd1 << bis_pkg::FRAC_BITS;
      neighbours(b, addr, fx, fy);
      w[0] = (one - fx) * (one - fy);
      w[1] = fx * (one - fy);
      w[2] = (one - fx) * fy;
      w[3] = fx * fy;
      for (int c = 0; c < 4; c++) begin
         acc = 0;
         for (int k = 0; k < 4; k++)
            acc += longint'((pixel_mem[addr[k]] >> (8 * c)) & 32'hFF) * w[k];
         acc >>= 2 * bis_pkg::FRAC_BITS;
         chan[c] = (acc > 255) ? 8'd255 : acc[7:0];
      end
      r.red   = chan[0];
      r.green = chan[1];
      r.blue  = chan[2];
      r.alpha = chan[3];
      r.col   = b.dcol;
      r.row   = b.drow;
      return r;
   endfunction

   task automatic send_beat(input pixel_beat_type b, input bit typed,
                            input pixel_res_type want);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_func     = b.func;
      req_src_col  = b.scol;
      req_src_row  = b.srow;
      req_in_red   = b.red;
      req_in_green = b.green;
      req_in_blue  = b.blue;
      req_in_alpha = b.alpha;
      req_dst_col  = b.dcol;
      req_dst_row  = b.drow;
      do @(posedge clock); while (req_stall);
      if (!b.func) begin
         pixel_mem[b.srow * bis_pkg::MAX_SRC_WIDTH + b.scol] =
            {b.alpha, b.blue, b.green, b.red};
         pixel_set[b.srow * bis_pkg::MAX_SRC_WIDTH + b.scol] = 1'b1;
      end else if (in_dest(b)) begin
         pending_pixels.push_back(typed ? want : blend_pixel(b));
      end
   endtask

   function automatic pixel_beat_type store_beat(input int col, input int row);
      pixel_beat_type b;
      b.func  = 1'b0;
      b.scol  = 9'(col);
      b.srow  = 9'(row);
      b.red   = 8'($urandom);
      b.green = 8'($urandom);
      b.blue  = 8'($urandom);
      b.alpha = 8'($urandom);
      b.dcol  = 12'($urandom);
      b.drow  = 12'($urandom);
      return b;
   endfunction

   // A request first gets any source pixel it would read written, so that
   // no never-written frame store entry is ever read.
   task automatic issue(input pixel_beat_type b, input bit typed, input pixel_res_type want);
      int addr [4];
      longint unsigned fx, fy;
      pixel_res_type none;
      none = '{default: 0};
      if (b.func && in_dest(b)) begin
         neighbours(b, addr, fx, fy);
         foreach (addr[k])
            if (!pixel_set[addr[k]])
               send_beat(store_beat(addr[k] % bis_pkg::MAX_SRC_WIDTH,
                                    addr[k] / bis_pkg::MAX_SRC_WIDTH), 0, none);
      end
      send_beat(b, typed, want);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(input bit [12:0] sw, input bit [12:0] sh, input bit [12:0] vx,
                            input bit [12:0] vy, input bit [12:0] vw, input bit [12:0] vh,
                            input bit [12:0] dw, input bit [12:0] dh);
      bit [12:0] vals [8];
      vals = '{sw, sh, vx, vy, vw, vh, dw, dh};
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_valid = 1'b1;
         csr_index = 3'(i);
         csr_data  = vals[i];
         do @(posedge clock); while (!csr_ready);
         cfg[i] = vals[i];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_random(input int count);
      pixel_beat_type b;
      pixel_res_type none;
      int dw, dh, sw, sh;
      none = '{default: 0};
      for (int n = 0; n < count; n++) begin
         dw = (cfg[bis_pkg::REG_DST_WIDTH] > 4096) ? 4096 : int'(cfg[bis_pkg::REG_DST_WIDTH]);
         dh = (cfg[bis_pkg::REG_DST_HEIGHT] > 4096) ? 4096
              : int'(cfg[bis_pkg::REG_DST_HEIGHT]);
         sw = int'(eff_size(cfg[bis_pkg::REG_SRC_WIDTH], bis_pkg::MAX_SRC_WIDTH));
         sh = int'(eff_size(cfg[bis_pkg::REG_SRC_HEIGHT], bis_pkg::MAX_SRC_HEIGHT));
         case ($urandom_range(0, 9))
            0: b = store_beat($urandom_range(0, 511), $urandom_range(0, 511));
            1, 2: b = store_beat($urandom_range(0, sw - 1), $urandom_range(0, sh - 1));
            3: begin
               b = store_beat(0, 0);
               b.func = 1'b1;
            end
            default: begin
               b = store_beat(0, 0);
               b.func = 1'b1;
               b.dcol = 12'($urandom_range(0, dw - 1));
               b.drow = 12'($urandom_range(0, dh - 1));
            end
         endcase
         issue(b, 0, none);
      end
   endtask

   task automatic add_row(input bit func, input int col, input int row, input bit [31:0] px,
                          input bit typed);
      table_row_type t;
      t.beat       = store_beat(0, 0);
      t.beat.func  = func;
      t.typed      = typed;
      if (func) begin
         t.beat.dcol = 12'(col);
         t.beat.drow = 12'(row);
      end else begin
         t.beat.scol = 9'(col);
         t.beat.srow = 9'(row);
      end
      {t.beat.alpha, t.beat.blue, t.beat.green, t.beat.red} = px;
      t.want = '{px[7:0], px[15:8], px[23:16], px[31:24], 12'(col), 12'(row)};
      directed.push_back(t);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holds_asked != holds_done) begin
         hold_left  = HOLD_CYCLES;
         holds_done = holds_asked;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         burst_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: result col %0d row %0d with nothing expected", $time,
                     rsp_out_col, rsp_out_row);
         end else begin
            pixel_res_type e;
            e = pending_pixels.pop_front();
            if ({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_out_col,
                 rsp_out_row} !== {e.red, e.green, e.blue, e.alpha, e.col, e.row}) begin
               errors++;
               $display({"%0t: mismatch expected rgba %h %h %h %h at %0d,%0d",
                         " got %h %h %h %h at %0d,%0d"},
                        $time, e.red, e.green, e.blue, e.alpha, e.col, e.row, rsp_out_red,
                        rsp_out_green, rsp_out_blue, rsp_out_alpha, rsp_out_col, rsp_out_row);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         watch_count = 0;
      else
         watch_count++;
      if (watch_count == WATCH_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = bis_pkg::REG_SRC_WIDTH;
      csr_data = '0;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_src_col = '0;
      req_src_row = '0;
      req_in_red = '0;
      req_in_green = '0;
      req_in_blue = '0;
      req_in_alpha = '0;
      req_dst_col = '0;
      req_dst_row = '0;
      cfg = '{512, 512, 0, 0, 512, 512, 512, 512};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(0, 0, 0, 32'h7F8000FF, 0);
      add_row(1, 0, 0, 32'h7F8000FF, 1);
      add_row(0, 511, 511, 32'hFE01FF00, 0);
      add_row(1, 511, 511, 32'hFE01FF00, 1);
      add_row(0, 511, 0, 32'hAA55AA55, 0);
      add_row(1, 511, 0, 32'hAA55AA55, 1);
      add_row(0, 0, 511, 32'h00000000, 0);
      add_row(1, 0, 511, 32'h00000000, 1);
      add_row(0, 256, 128, 32'hFFFFFFFF, 0);
      add_row(1, 256, 128, 32'hFFFFFFFF, 1);
      add_row(1, 512, 0, 0, 0);
      add_row(1, 0, 512, 0, 0);
      add_row(1, 4095, 4095, 0, 0);
      add_row(1, 7, 3, 0, 0);
      foreach (directed[i])
         issue(directed[i].beat, directed[i].typed, directed[i].want);
      drain();

      configure(4, 3, 1, 2, 7, 5, 16, 12);
      issue('{1, 0, 0, 0, 0, 0, 0, 15, 11}, 0, '{default: 0});
      run_random(80);
      drain();

      configure(0, 1023, 511, 0, 0, 1023, 8191, 4096);
      run_random(40);
      drain();

      configure(16, 16, 3, 9, 5, 9, 1, 1);
      run_random(60);
      drain();

      configure(9, 6, 0, 511, 512, 1, 40, 30);
      holds_asked++;
      run_random(120);
      drain();

      quiet = 1'b1;
      configure(2, 2, 5, 5, 3, 3, 4096, 8191);
      run_random(120);
      drain();

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
